// ===== rtl/efc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge flux coefficients: shared package
// Field widths, intermediate widths, register indexes and configuration type.
// ----------------------------------------------------------------------------
package efc_pkg;

    localparam int C_W       = 32;
    localparam int V_W       = 18;
    localparam int K_W       = 21;
    localparam int ROW_W     = 63;
    localparam int LEN_W     = 31;
    localparam int P_W       = 36;
    localparam int KP_W      = 57;
    localparam int KPS_W     = 59;
    localparam int EA_W      = 26;
    localparam int KVP_W     = 39;
    localparam int KVS_W     = 41;
    localparam int KV_W      = 25;
    localparam int DP_W      = 57;
    localparam int DOT_W     = 59;
    localparam int EP_W      = 58;
    localparam int ES_W      = 60;
    localparam int ER_W      = 44;
    localparam int NUM_W     = 61;
    localparam int Q_W       = 33;
    localparam int FRAC_W    = 16;
    localparam int EA_SHIFT  = 33;
    localparam int HALF_SH   = 15;
    localparam int DIV_STEPS = 33;
    localparam int DIV_LAT   = DIV_STEPS + 4;
    localparam int FRONT_LAT = 5;
    localparam int ADDR_W    = 6;
    localparam int DATA_W    = 64;

    localparam logic [2:0] REG_K_ROW0 = 3'd0;
    localparam logic [2:0] REG_K_ROW1 = 3'd1;
    localparam logic [2:0] REG_K_ROW2 = 3'd2;
    localparam logic [2:0] REG_MESH3D = 3'd3;
    localparam logic [2:0] REG_K_ISO  = 3'd4;

    typedef logic signed [C_W-1:0]   coef_t;
    typedef logic signed [V_W-1:0]   dir_t;
    typedef logic signed [K_W-1:0]   k_t;
    typedef logic        [LEN_W-1:0] len_t;
    typedef logic signed [NUM_W-1:0] num_t;

    typedef struct packed {
        logic [2:0][ROW_W-1:0] k_rows;
        logic                  mesh_3d;
        logic                  k_isotropic;
    } cfg_t;

endpackage

// ===== rtl/efc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge flux coefficients: tensor front end
// Five-stage pipeline forming K S, K v, the E vector and the divider operands.
// ----------------------------------------------------------------------------
module efc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  efc_pkg::cfg_t       cfg,
    input  logic                in_valid,
    input  efc_pkg::coef_t      coef [3],
    input  efc_pkg::dir_t       dir [3],
    input  efc_pkg::len_t       len_in [3],
    output logic                out_valid,
    output efc_pkg::coef_t      e_out [3],
    output efc_pkg::num_t       g_num,
    output efc_pkg::num_t       fi_num [3],
    output efc_pkg::num_t       fj_num [3],
    output efc_pkg::len_t       len_out [3]
);
    import efc_pkg::*;

    localparam logic signed [P_W-1:0]   P_UNIT   = 36'sh1_0000_0000;
    localparam logic signed [P_W-1:0]   P_NIL    = 36'sh0;
    localparam logic signed [KVS_W-1:0] KVS_HALF = 41'sh8000;
    localparam logic signed [KPS_W-1:0] KPS_HALF = 59'sh1_0000_0000;
    localparam logic signed [ES_W-1:0]  ES_HALF  = 60'sh8000;
    localparam logic signed [ER_W-1:0]  ER_MAX   = 44'sh0_7FFF_FFFF;
    localparam logic signed [ER_W-1:0]  ER_MIN   = -44'sh0_8000_0000;

    k_t                      km [3][3];
    coef_t                   cm [3];
    dir_t                    vm [3];

    logic [FRONT_LAT-1:0]    vld_reg;

    logic signed [P_W-1:0]   pp_next [3][3];
    logic signed [P_W-1:0]   pp_reg [3][3];
    logic signed [KVP_W-1:0] kvp_next [3][3];
    logic signed [KVP_W-1:0] kvp_reg [3][3];
    coef_t                   c1_reg [3];

    logic signed [KP_W-1:0]  kpp_next [3][3][3];
    logic signed [KP_W-1:0]  kpp_reg [3][3][3];
    logic signed [KVS_W-1:0] kvs [3];
    logic signed [KV_W-1:0]  kv_next [3];
    logic signed [KV_W-1:0]  kv_reg [3];
    coef_t                   c2_reg [3];

    logic signed [KPS_W-1:0] kps [3][3];
    logic signed [EA_W-1:0]  ea_next [3][3];
    logic signed [EA_W-1:0]  ea_reg [3][3];
    logic signed [DP_W-1:0]  dp_next [3];
    logic signed [DP_W-1:0]  dp_reg [3];
    coef_t                   c3_reg [3];

    logic signed [EP_W-1:0]  ep_next [3][3];
    logic signed [EP_W-1:0]  ep_reg [3][3];
    logic signed [DOT_W-1:0] dot_next;
    logic signed [DOT_W-1:0] dot_reg;
    coef_t                   c4_reg [3];

    logic signed [ES_W-1:0]  es [3];
    logic signed [ER_W-1:0]  er [3];
    coef_t                   e_next [3];
    coef_t                   e_reg [3];
    num_t                    fn [3];
    num_t                    g_reg;
    num_t                    fi_reg [3];
    num_t                    fj_reg [3];

    len_t                    len_reg [FRONT_LAT][3];

    // mask the tensor and the vectors by mode
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if ((cfg.k_isotropic && i != j) || (!cfg.mesh_3d && (i == 2 || j == 2)))
                    km[i][j] = '0;
                else
                    km[i][j] = k_t'(cfg.k_rows[i][K_W*j +: K_W]);
            end
            cm[i] = (!cfg.mesh_3d && i == 2) ? '0 : coef[i];
            vm[i] = (!cfg.mesh_3d && i == 2) ? '0 : dir[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                pp_next[i][j]  = (P_W'(vm[i]) * P_W'(vm[j])) - ((i == j) ? P_UNIT : P_NIL);
                kvp_next[i][j] = KVP_W'(km[i][j]) * KVP_W'(vm[j]);
                for (int m = 0; m < 3; m++)
                    kpp_next[i][j][m] = KP_W'(km[i][m]) * KP_W'(pp_reg[m][j]);
                kps[i][j] = KPS_W'(kpp_reg[i][j][0]) + KPS_W'(kpp_reg[i][j][1])
                          + KPS_W'(kpp_reg[i][j][2]) + KPS_HALF;
                ea_next[i][j] = EA_W'(kps[i][j] >>> EA_SHIFT);
                ep_next[i][j] = EP_W'(c3_reg[j]) * EP_W'(ea_reg[j][i]);
            end
            kvs[i] = KVS_W'(kvp_reg[i][0]) + KVS_W'(kvp_reg[i][1])
                   + KVS_W'(kvp_reg[i][2]) + KVS_HALF;
            kv_next[i] = KV_W'(kvs[i] >>> FRAC_W);
            dp_next[i] = DP_W'(c2_reg[i]) * DP_W'(kv_reg[i]);
            es[i] = ES_W'(ep_reg[i][0]) + ES_W'(ep_reg[i][1]) + ES_W'(ep_reg[i][2]) + ES_HALF;
            er[i] = ER_W'(es[i] >>> FRAC_W);
            if (er[i] > ER_MAX)
                e_next[i] = coef_t'(ER_MAX);
            else if (er[i] < ER_MIN)
                e_next[i] = coef_t'(ER_MIN);
            else
                e_next[i] = coef_t'(er[i]);
            fn[i] = NUM_W'(c4_reg[i]) <<< HALF_SH;
        end
        dot_next = DOT_W'(dp_reg[0]) + DOT_W'(dp_reg[1]) + DOT_W'(dp_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[FRONT_LAT-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_reg   <= pp_next;
            kvp_reg  <= kvp_next;
            c1_reg   <= cm;
            kpp_reg  <= kpp_next;
            kv_reg   <= kv_next;
            c2_reg   <= c1_reg;
            ea_reg   <= ea_next;
            dp_reg   <= dp_next;
            c3_reg   <= c2_reg;
            ep_reg   <= ep_next;
            dot_reg  <= dot_next;
            c4_reg   <= c3_reg;
            e_reg    <= e_next;
            g_reg    <= -NUM_W'(dot_reg);
            for (int i = 0; i < 3; i++)
            begin
                fi_reg[i] <= fn[i];
                fj_reg[i] <= -fn[i];
            end
            len_reg[0] <= len_in;
            for (int s = 1; s < FRONT_LAT; s++)
                len_reg[s] <= len_reg[s-1];
        end
    end

    assign out_valid = vld_reg[FRONT_LAT-1];
    assign e_out     = e_reg;
    assign g_num     = g_reg;
    assign fi_num    = fi_reg;
    assign fj_num    = fj_reg;
    assign len_out   = len_reg[FRONT_LAT-1];

endmodule

// ===== rtl/efc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge flux coefficients: pipelined divider
// Signed dividend over unsigned divisor, rounded half away from zero,
// saturated to 32 bits; one quotient bit per stage.
// ----------------------------------------------------------------------------
module efc_div (
    input  logic           clk,
    input  logic           en,
    input  efc_pkg::num_t  num,
    input  efc_pkg::len_t  den,
    output efc_pkg::coef_t q
);
    import efc_pkg::*;

    localparam logic [Q_W-1:0] Q_POS_MAX = 33'h0_7FFF_FFFF;
    localparam logic [Q_W-1:0] Q_NEG_MAX = 33'h0_8000_0000;
    localparam coef_t C_MAX = 32'sh7FFF_FFFF;
    localparam coef_t C_MIN = 32'sh8000_0000;

    logic [NUM_W-1:0] mag_reg;
    logic             neg_a_reg;
    len_t             den_a_reg;

    logic [NUM_W-1:0] n_reg;
    logic             neg_b_reg;
    logic             zero_b_reg;
    len_t             den_b_reg;

    logic [C_W-1:0]   rem_reg  [DIV_STEPS+1];
    logic [Q_W-1:0]   nl_reg   [DIV_STEPS+1];
    logic [Q_W-1:0]   qb_reg   [DIV_STEPS+1];
    logic             ovf_reg  [DIV_STEPS+1];
    logic             neg_reg  [DIV_STEPS+1];
    logic             zero_reg [DIV_STEPS+1];
    len_t             den_reg  [DIV_STEPS+1];

    logic [Q_W-1:0]   qf;
    coef_t            q_next;
    coef_t            q_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_a_reg  <= num[NUM_W-1];
            mag_reg    <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            den_a_reg  <= den;
            n_reg      <= mag_reg + NUM_W'(den_a_reg >> 1);
            zero_b_reg <= (mag_reg == '0);
            neg_b_reg  <= neg_a_reg;
            den_b_reg  <= den_a_reg;
            rem_reg[0]  <= C_W'(n_reg[NUM_W-1:Q_W]);
            nl_reg[0]   <= n_reg[Q_W-1:0];
            qb_reg[0]   <= '0;
            ovf_reg[0]  <= (C_W'(n_reg[NUM_W-1:Q_W]) >= C_W'(den_b_reg));
            neg_reg[0]  <= neg_b_reg;
            zero_reg[0] <= zero_b_reg;
            den_reg[0]  <= den_b_reg;
        end
    end

    for (genvar s = 1; s <= DIV_STEPS; s++)
    begin : g_step
        logic [C_W-1:0] t;
        assign t = {rem_reg[s-1][C_W-2:0], nl_reg[s-1][DIV_STEPS-s]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (t >= C_W'(den_reg[s-1]))
                begin
                    rem_reg[s] <= t - C_W'(den_reg[s-1]);
                    qb_reg[s]  <= {qb_reg[s-1][Q_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[s] <= t;
                    qb_reg[s]  <= {qb_reg[s-1][Q_W-2:0], 1'b0};
                end
                nl_reg[s]   <= nl_reg[s-1];
                ovf_reg[s]  <= ovf_reg[s-1];
                neg_reg[s]  <= neg_reg[s-1];
                zero_reg[s] <= zero_reg[s-1];
                den_reg[s]  <= den_reg[s-1];
            end
        end
    end

    assign qf = qb_reg[DIV_STEPS];

    always_comb
    begin
        if (zero_reg[DIV_STEPS])
            q_next = '0;
        else if (ovf_reg[DIV_STEPS])
            q_next = neg_reg[DIV_STEPS] ? C_MIN : C_MAX;
        else if (!neg_reg[DIV_STEPS])
            q_next = (qf > Q_POS_MAX) ? C_MAX : coef_t'(qf[C_W-1:0]);
        else
            q_next = (qf > Q_NEG_MAX) ? C_MIN : -coef_t'(qf[C_W-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

// ===== rtl/edge_flux_coefficients_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge flux coefficients: top level
// An accepted item passes 5 tensor stages, 37 divider stages and 1 output
// register to out_valid. Throughput: one item per cycle while not stalled.
// A stall on the output with a result waiting freezes the whole pipeline.
// Reset clears all valid bits and loads K = 0, 2-D mode, isotropic mode.
// ----------------------------------------------------------------------------
module edge_flux_coefficients_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [efc_pkg::ADDR_W-1:0] paddr,
    input  logic [efc_pkg::DATA_W-1:0] pwdata,
    output logic [efc_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [31:0]         coef_x,
    input  logic signed [31:0]         coef_y,
    input  logic signed [31:0]         coef_z,
    input  logic signed [17:0]         dir_x,
    input  logic signed [17:0]         dir_y,
    input  logic signed [17:0]         dir_z,
    input  logic [30:0]                edge_length,
    input  logic [30:0]                volume_i,
    input  logic [30:0]                volume_j,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [31:0]         e_x,
    output logic signed [31:0]         e_y,
    output logic signed [31:0]         e_z,
    output logic signed [31:0]         g_coef,
    output logic signed [31:0]         fi_x,
    output logic signed [31:0]         fi_y,
    output logic signed [31:0]         fi_z,
    output logic signed [31:0]         fj_x,
    output logic signed [31:0]         fj_y,
    output logic signed [31:0]         fj_z
);
    import efc_pkg::*;

    cfg_t               cfg_reg;
    logic [2:0]         reg_idx;
    logic               en;

    coef_t              coef_a [3];
    dir_t               dir_a [3];
    len_t               len_a [3];

    logic               f_valid;
    coef_t              f_e [3];
    num_t               f_g;
    num_t               f_fi [3];
    num_t               f_fj [3];
    len_t               f_len [3];

    coef_t              q_g;
    coef_t              q_fi [3];
    coef_t              q_fj [3];

    logic [DIV_LAT-1:0] dvld_reg;
    coef_t              edly_reg [DIV_LAT][3];

    logic               out_valid_reg;
    coef_t              e_reg [3];
    coef_t              g_reg;
    coef_t              fi_reg [3];
    coef_t              fj_reg [3];

    assign reg_idx = paddr[ADDR_W-1:3];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.k_rows      <= '0;
            cfg_reg.mesh_3d     <= 1'b0;
            cfg_reg.k_isotropic <= 1'b1;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_idx)
                REG_K_ROW0: cfg_reg.k_rows[0]   <= pwdata[ROW_W-1:0];
                REG_K_ROW1: cfg_reg.k_rows[1]   <= pwdata[ROW_W-1:0];
                REG_K_ROW2: cfg_reg.k_rows[2]   <= pwdata[ROW_W-1:0];
                REG_MESH3D: cfg_reg.mesh_3d     <= pwdata[0];
                REG_K_ISO:  cfg_reg.k_isotropic <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_K_ROW0: prdata = DATA_W'(cfg_reg.k_rows[0]);
            REG_K_ROW1: prdata = DATA_W'(cfg_reg.k_rows[1]);
            REG_K_ROW2: prdata = DATA_W'(cfg_reg.k_rows[2]);
            REG_MESH3D: prdata = DATA_W'(cfg_reg.mesh_3d);
            REG_K_ISO:  prdata = DATA_W'(cfg_reg.k_isotropic);
            default:    prdata = '0;
        endcase
    end

    // advance unless a result waits and is stalled
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    always_comb
    begin
        coef_a[0] = coef_x;
        coef_a[1] = coef_y;
        coef_a[2] = coef_z;
        dir_a[0]  = dir_x;
        dir_a[1]  = dir_y;
        dir_a[2]  = dir_z;
        len_a[0]  = edge_length;
        len_a[1]  = volume_i;
        len_a[2]  = volume_j;
    end

    efc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .coef      (coef_a),
        .dir       (dir_a),
        .len_in    (len_a),
        .out_valid (f_valid),
        .e_out     (f_e),
        .g_num     (f_g),
        .fi_num    (f_fi),
        .fj_num    (f_fj),
        .len_out   (f_len)
    );

    efc_div u_div_g (
        .clk (clk),
        .en  (en),
        .num (f_g),
        .den (f_len[0]),
        .q   (q_g)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_grad
        efc_div u_div_fi (
            .clk (clk),
            .en  (en),
            .num (f_fi[i]),
            .den (f_len[1]),
            .q   (q_fi[i])
        );
        efc_div u_div_fj (
            .clk (clk),
            .en  (en),
            .num (f_fj[i]),
            .den (f_len[2]),
            .q   (q_fj[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dvld_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            dvld_reg      <= {dvld_reg[DIV_LAT-2:0], f_valid};
            out_valid_reg <= dvld_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            edly_reg[0] <= f_e;
            for (int s = 1; s < DIV_LAT; s++)
                edly_reg[s] <= edly_reg[s-1];
            e_reg  <= edly_reg[DIV_LAT-1];
            g_reg  <= q_g;
            fi_reg <= q_fi;
            fj_reg <= q_fj;
        end
    end

    assign out_valid = out_valid_reg;
    assign e_x       = e_reg[0];
    assign e_y       = e_reg[1];
    assign e_z       = e_reg[2];
    assign g_coef    = g_reg;
    assign fi_x      = fi_reg[0];
    assign fi_y      = fi_reg[1];
    assign fi_z      = fi_reg[2];
    assign fj_x      = fj_reg[0];
    assign fj_y      = fj_reg[1];
    assign fj_z      = fj_reg[2];

    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result waiting");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(g_coef) && $stable(e_x)
                                   && $stable(fj_z))
        else $error("stalled result changed");

    a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(dvld_reg))
        else $error("pipeline moved during stall");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge flux coefficients testbench
// Streams mesh edges through the block under random valid and stall patterns,
// predicts the E, G and gradient coefficients in fixed point and checks every
// result field in order. The tensor and mode registers are rewritten between
// phases through the register port.
// ----------------------------------------------------------------------------
module testbench;
    import efc_pkg::*;

    typedef struct {
        logic signed [31:0] cx, cy, cz;
        logic signed [17:0] vx, vy, vz;
        logic [30:0] len, voli, volj;
    } edge_t;

    typedef struct {
        logic signed [31:0] ex, ey, ez, g, fix, fiy, fiz, fjx, fjy, fjz;
    } coefs_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [31:0] coef_x = 0, coef_y = 0, coef_z = 0;
    logic signed [17:0] dir_x = 0, dir_y = 0, dir_z = 0;
    logic [30:0] edge_length = 0, volume_i = 0, volume_j = 0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] e_x, e_y, e_z, g_coef, fi_x, fi_y, fi_z, fj_x, fj_y, fj_z;

    edge_flux_coefficients_top dut (.*);

    always #5 clk = ~clk;

    logic [ROW_W-1:0] k_rows [3];
    logic mesh_3d_q, k_iso_q;

    edge_t  pending_edges [$];
    coefs_t expected_coefs [$];
    int send_idle_pct = 0, recv_idle_pct = 0;
    int hold_off_cycles = 0;
    int mismatches = 0;

    function automatic longint round_shift(longint x, int s);
        longint y;
        y = x + (longint'(1) << (s - 1));
        return y >>> s;
    endfunction

    function automatic longint sat_i32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint div_nearest(longint num, longint den);
        longint unsigned mag, q;
        if (den == 0) return num > 0 ? 64'sd2147483647 : (num < 0 ? -64'sd2147483648 : 0);
        mag = num < 0 ? -num : num;
        q = (mag + den / 2) / den;
        if (q > 64'h1_0000_0000) q = 64'h1_0000_0000;
        return sat_i32(num < 0 ? -longint'(q) : longint'(q));
    endfunction

    function automatic coefs_t edge_coefs(edge_t it);
        longint c[3], v[3], k[3][3], p[3][3], ea[3][3], o[3], fi[3], fj[3];
        longint acc, dot;
        int dim;
        coefs_t r;
        dim = mesh_3d_q ? 3 : 2;
        c[0] = it.cx; c[1] = it.cy; c[2] = it.cz;
        v[0] = it.vx; v[1] = it.vy; v[2] = it.vz;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                k[i][j] = longint'($signed(k_rows[i][21*j +: 21]));
                if (k_iso_q && i != j) k[i][j] = 0;
            end
        if (dim == 2)
        begin
            c[2] = 0;
            v[2] = 0;
        end
        for (int i = 0; i < dim; i++)
            for (int j = 0; j < dim; j++)
                p[i][j] = v[i] * v[j] - (i == j ? (longint'(1) << 32) : 0);
        for (int i = 0; i < dim; i++)
            for (int j = 0; j < dim; j++)
            begin
                acc = 0;
                for (int m = 0; m < dim; m++) acc += k[i][m] * p[m][j];
                ea[i][j] = round_shift(acc, 33);
            end
        for (int i = 0; i < 3; i++)
        begin
            acc = 0;
            if (i < dim)
                for (int j = 0; j < dim; j++) acc += c[j] * ea[j][i];
            o[i] = sat_i32(round_shift(acc, 16));
        end
        dot = 0;
        for (int i = 0; i < dim; i++)
        begin
            acc = 0;
            for (int j = 0; j < dim; j++) acc += k[i][j] * v[j];
            dot += c[i] * round_shift(acc, 16);
        end
        for (int i = 0; i < 3; i++)
        begin
            fi[i] = i < dim ? div_nearest(c[i] * 32768, it.voli) : 0;
            fj[i] = i < dim ? div_nearest(-c[i] * 32768, it.volj) : 0;
        end
        r.ex = o[0]; r.ey = o[1]; r.ez = o[2];
        r.g = div_nearest(-dot, it.len);
        r.fix = fi[0]; r.fiy = fi[1]; r.fiz = fi[2];
        r.fjx = fj[0]; r.fjy = fj[1]; r.fjz = fj[2];
        return r;
    endfunction

    // driver
    edge_t cur;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || !in_stall)
            begin
                if (pending_edges.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur = pending_edges.pop_front();
                    expected_coefs.push_back(edge_coefs(cur));
                    in_valid <= 1'b1;
                    coef_x <= cur.cx; coef_y <= cur.cy; coef_z <= cur.cz;
                    dir_x <= cur.vx; dir_y <= cur.vy; dir_z <= cur.vz;
                    edge_length <= cur.len; volume_i <= cur.voli; volume_j <= cur.volj;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver stall
    always @(posedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        coefs_t x, a;
        if (rst_n && out_valid && !out_stall)
        begin
            a.ex = e_x; a.ey = e_y; a.ez = e_z; a.g = g_coef;
            a.fix = fi_x; a.fiy = fi_y; a.fiz = fi_z;
            a.fjx = fj_x; a.fjy = fj_y; a.fjz = fj_z;
            if (expected_coefs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result at %0t", $time);
            end
            else
            begin
                x = expected_coefs.pop_front();
                if (x != a)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp e=%0d %0d %0d g=%0d fi=%0d %0d %0d fj=%0d %0d %0d got e=%0d %0d %0d g=%0d fi=%0d %0d %0d fj=%0d %0d %0d",
                            x.ex, x.ey, x.ez, x.g, x.fix, x.fiy, x.fiz, x.fjx, x.fjy, x.fjz,
                            a.ex, a.ey, a.ez, a.g, a.fix, a.fiy, a.fiz, a.fjx, a.fjy, a.fjz);
                end
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(posedge clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= ADDR_W'(8 * idx); pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_K_ROW0: k_rows[0] = val[ROW_W-1:0];
            REG_K_ROW1: k_rows[1] = val[ROW_W-1:0];
            REG_K_ROW2: k_rows[2] = val[ROW_W-1:0];
            REG_MESH3D: mesh_3d_q = val[0];
            default: k_iso_q = val[0];
        endcase
    endtask

    task automatic wait_drained();
        while (pending_edges.size() > 0 || expected_coefs.size() > 0 || in_valid)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic logic [20:0] rand_k();
        case ($urandom_range(5))
            0: return 21'h0FFFFF;
            1: return 21'h100000;
            2: return 21'h010000;
            default: return 21'($urandom);
        endcase
    endfunction

    task automatic set_config(bit m3, bit iso, bit extreme);
        logic [62:0] row;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
                row[21*c +: 21] = extreme ? (((r + c) % 2) ? 21'h100000 : 21'h0FFFFF)
                                          : rand_k();
            write_reg(3'(r), {1'b1, row});
        end
        write_reg(REG_MESH3D, {63'($urandom), m3});
        write_reg(REG_K_ISO, {63'($urandom), iso});
    endtask

    function automatic logic [30:0] rand_pos();
        case ($urandom_range(9))
            0: return 0;
            1: return 31'h7FFFFFFF;
            2: return 31'd1;
            3, 4: return 31'($urandom_range(32'h0001_0000, 32'h0010_0000));
            default: return 31'($urandom);
        endcase
    endfunction

    function automatic logic signed [17:0] rand_dir();
        case ($urandom_range(9))
            0: return 18'sd65536;
            1: return -18'sd65536;
            2: return 18'($urandom);
            default: return 18'($signed($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_coef();
        case ($urandom_range(7))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_random(int n);
        edge_t it;
        repeat (n)
        begin
            it.cx = rand_coef(); it.cy = rand_coef(); it.cz = rand_coef();
            it.vx = rand_dir(); it.vy = rand_dir(); it.vz = rand_dir();
            it.len = rand_pos(); it.voli = rand_pos(); it.volj = rand_pos();
            pending_edges.push_back(it);
        end
    endtask

    task automatic queue_directed();
        edge_t it;
        logic signed [31:0] cv [4] = '{32'h7FFFFFFF, 32'h80000000, 0, 32'h00010000};
        logic signed [17:0] dv [4] = '{18'sd65536, -18'sd65536, 0, 18'h1FFFF};
        logic [30:0] lv [4] = '{31'h7FFFFFFF, 0, 31'd1, 31'h00010000};
        for (int i = 0; i < 16; i++)
        begin
            it.cx = cv[i % 4]; it.cy = cv[(i / 4) % 4]; it.cz = cv[(i + 1) % 4];
            it.vx = dv[i % 4]; it.vy = dv[(i + 2) % 4]; it.vz = dv[(i / 4) % 4];
            it.len = lv[i % 4]; it.voli = lv[(i + 1) % 4]; it.volj = lv[(i / 4) % 4];
            pending_edges.push_back(it);
        end
    endtask

    initial
    begin
        k_rows[0] = '0; k_rows[1] = '0; k_rows[2] = '0;
        mesh_3d_q = 1'b0; k_iso_q = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        queue_directed();
        wait_drained();
        set_config(1'b1, 1'b0, 1'b1);
        queue_directed();
        wait_drained();

        send_idle_pct = 29; recv_idle_pct = 83;
        set_config(1'b1, 1'b0, 1'b0);
        queue_random(140);
        wait_drained();

        send_idle_pct = 83; recv_idle_pct = 29;
        set_config(1'b0, 1'b0, 1'b0);
        queue_random(130);
        wait_drained();

        send_idle_pct = 0; recv_idle_pct = 0;
        set_config(1'b1, 1'b1, 1'b0);
        queue_random(60);
        hold_off_cycles = 200;
        wait_drained();

        set_config(1'b0, 1'b1, 1'b1);
        queue_random(100);
        wait_drained();

        set_config(1'b1, 1'b0, 1'b0);
        queue_random(100);
        wait_drained();

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end
endmodule
